// ===== hw/rtl/four_channel_coincidence_builder_assert.svh =====
// Assertion macros used by the checker of the coincidence builder.
`ifndef FOUR_CHANNEL_COINCIDENCE_BUILDER_ASSERT_SVH
`define FOUR_CHANNEL_COINCIDENCE_BUILDER_ASSERT_SVH

// Clocked property that is switched off while reset is low.
`define FCCB_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that is also checked during reset.
`define FCCB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/fccb_pkg.sv =====
// Shared constants, types and helper functions of the coincidence builder.
`timescale 1ns / 1ps

package fccb_pkg;

  localparam int WINDOW_HITS   = 4;
  localparam int CHANNEL_LIMIT = 14;
  localparam int STAMP_BITS    = 48;

  localparam int CHAN_W     = 5;
  localparam int ENERGY_W   = 24;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int DIFF_W     = 24;
  localparam int ASYM_W     = 16;
  localparam int QUOT_W     = 16;
  localparam int PROD_W     = ENERGY_W + CFG_W;
  localparam int DEN_W      = PROD_W + 1;
  localparam int REM_W      = PROD_W + 2;
  localparam int WIN_IDX_W  = $clog2(WINDOW_HITS);
  localparam int WIN_CNT_W  = $clog2(WINDOW_HITS + 1);
  localparam int MUL_STEP_W = $clog2(CFG_W);
  localparam int DIV_STEP_W = $clog2(QUOT_W);

  // Stamp differences are clamped to +-2^61, which only bites for very wide stamps.
  localparam int TD_W     = (STAMP_BITS + 1 > 62) ? 63 : STAMP_BITS + 1;
  localparam int CMP_W    = (STAMP_BITS + 1 > 63) ? STAMP_BITS + 1 : 63;
  localparam int SUM_W    = TD_W + 2;
  localparam int SAT_IN_W = SUM_W + 1;

  localparam int TIME_BIAS = 640;

  localparam logic [CFG_IDX_W-1:0] REG_COINC_WIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAIR1_OFS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAIR2_OFS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_CH0  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_CH1  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_CH2  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_CH3  = 3'd6;

  localparam logic [CFG_W-1:0] RST_COINC_WIN = 16'd640;
  localparam logic [CFG_W-1:0] RST_GAIN      = 16'd4096;

  typedef logic [CHAN_W-1:0]            chan_t;
  typedef logic [STAMP_BITS-1:0]        stamp_t;
  typedef logic [ENERGY_W-1:0]          energy_t;
  typedef logic [PROD_W-1:0]            prod_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [ASYM_W-1:0]     asym_t;
  typedef logic signed [TD_W-1:0]       td_t;
  typedef logic signed [SUM_W-1:0]      sum_t;
  typedef logic signed [SAT_IN_W-1:0]   sat_t;
  typedef stamp_t  [WINDOW_HITS-1:0]    stamp_arr_t;
  typedef energy_t [WINDOW_HITS-1:0]    energy_arr_t;

  typedef struct packed {
    chan_t   chan;
    stamp_t  stamp;
    logic    stamp_ok;
    energy_t energy;
  } win_hit_t;

  typedef struct packed {
    logic full;
    logic qual;
  } win_stat_t;

  typedef struct packed {
    stamp_arr_t  stamp;
    energy_arr_t energy;
  } ord_hits_t;

  typedef struct packed {
    diff_t mean_diff;
    diff_t diff_02;
    diff_t diff_13;
    diff_t diff_03;
    diff_t diff_12;
    diff_t pair1_delta;
    diff_t pair2_delta;
  } time_res_t;

  localparam logic signed [CMP_W-1:0] DIFF_CLAMP = {{(CMP_W - 62){1'b0}}, 1'b1, 61'd0};
  localparam sat_t  SAT_HI   = sat_t'((2 ** (DIFF_W - 1)) - 1);
  localparam sat_t  SAT_LO   = ~SAT_HI;
  localparam sat_t  BIAS_S   = sat_t'(TIME_BIAS);
  localparam asym_t ASYM_MAX = asym_t'((2 ** (ASYM_W - 1)) - 1);

  function automatic td_t sdiff(input stamp_t a, input stamp_t b);
    logic signed [STAMP_BITS:0] raw;
    logic signed [CMP_W-1:0]    w;
    raw = $signed({1'b0, a}) - $signed({1'b0, b});
    w   = CMP_W'(raw);
    if (w > DIFF_CLAMP) begin
      w = DIFF_CLAMP;
    end else if (w < -DIFF_CLAMP) begin
      w = -DIFF_CLAMP;
    end
    return td_t'(w);
  endfunction

  function automatic diff_t sat_diff(input sat_t v);
    if (v > SAT_HI) begin
      return SAT_HI[DIFF_W-1:0];
    end else if (v < SAT_LO) begin
      return SAT_LO[DIFF_W-1:0];
    end
    return v[DIFF_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/fccb_if.sv =====
// Valid/ready channel interfaces for hits in and coincidence results out.
`timescale 1ns / 1ps

interface fccb_in_if;
  logic             valid;
  logic             ready;
  fccb_pkg::chan_t  hit_chan;
  fccb_pkg::stamp_t hit_stamp;
  logic             stamp_ok;
  fccb_pkg::energy_t hit_energy;

  modport source (output valid, output hit_chan, output hit_stamp, output stamp_ok,
                  output hit_energy, input ready);
  modport sink (input valid, input hit_chan, input hit_stamp, input stamp_ok,
                input hit_energy, output ready);
endinterface

interface fccb_out_if;
  logic            valid;
  logic            ready;
  fccb_pkg::diff_t mean_diff;
  fccb_pkg::diff_t diff_02;
  fccb_pkg::diff_t diff_13;
  fccb_pkg::diff_t diff_03;
  fccb_pkg::diff_t diff_12;
  fccb_pkg::diff_t pair1_delta;
  fccb_pkg::diff_t pair2_delta;
  fccb_pkg::asym_t asym1_raw;
  fccb_pkg::asym_t asym2_raw;
  fccb_pkg::asym_t asym1_gain;
  fccb_pkg::asym_t asym2_gain;

  modport source (output valid, output mean_diff, output diff_02, output diff_13,
                  output diff_03, output diff_12, output pair1_delta, output pair2_delta,
                  output asym1_raw, output asym2_raw, output asym1_gain, output asym2_gain,
                  input ready);
  modport sink (input valid, input mean_diff, input diff_02, input diff_13,
                input diff_03, input diff_12, input pair1_delta, input pair2_delta,
                input asym1_raw, input asym2_raw, input asym1_gain, input asym2_gain,
                output ready);
endinterface

// ===== hw/rtl/fccb_window.sv =====
// Rolling window of the last four hits with event qualification and channel sort.
`timescale 1ns / 1ps

module fccb_window (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  fccb_pkg::win_hit_t   hit,
  output fccb_pkg::win_stat_t  stat,
  output fccb_pkg::ord_hits_t  ord
);

  localparam int NH  = fccb_pkg::WINDOW_HITS;
  localparam int IW  = fccb_pkg::WIN_IDX_W;
  localparam int CW  = fccb_pkg::WIN_CNT_W;
  localparam int CHW = fccb_pkg::CHAN_W;

  fccb_pkg::chan_t   chan_r   [NH];
  fccb_pkg::stamp_t  stamp_r  [NH];
  logic              ok_r     [NH];
  fccb_pkg::energy_t energy_r [NH];
  logic [CW-1:0]     count_r;
  logic [CW-1:0]     count_nxt;
  logic              full;
  logic [IW-1:0]     rank [NH];

  assign full = (count_r == CW'(NH));

  always_comb begin
    count_nxt = count_r;
    if (push && !full) begin
      count_nxt = count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Once the window is full, each new hit pushes the oldest one out.
  always_ff @(posedge clk) begin
    if (push) begin
      if (full) begin
        for (int i = 0; i < NH - 1; i++) begin
          chan_r[i]   <= chan_r[i+1];
          stamp_r[i]  <= stamp_r[i+1];
          ok_r[i]     <= ok_r[i+1];
          energy_r[i] <= energy_r[i+1];
        end
        chan_r[NH-1]   <= hit.chan;
        stamp_r[NH-1]  <= hit.stamp;
        ok_r[NH-1]     <= hit.stamp_ok;
        energy_r[NH-1] <= hit.energy;
      end else begin
        chan_r[count_r[IW-1:0]]   <= hit.chan;
        stamp_r[count_r[IW-1:0]]  <= hit.stamp;
        ok_r[count_r[IW-1:0]]     <= hit.stamp_ok;
        energy_r[count_r[IW-1:0]] <= hit.energy;
      end
    end
  end

  always_comb begin
    stat.full = full;
    stat.qual = 1'b1;
    for (int i = 0; i < NH; i++) begin
      if (chan_r[i] >= CHW'(fccb_pkg::CHANNEL_LIMIT) || !ok_r[i] || energy_r[i] == '0) begin
        stat.qual = 1'b0;
      end
      for (int j = 0; j < i; j++) begin
        if (chan_r[j] == chan_r[i]) begin
          stat.qual = 1'b0;
        end
      end
    end
  end

  // The rank of a hit is the number of window hits on a lower channel.
  always_comb begin
    for (int i = 0; i < NH; i++) begin
      rank[i] = '0;
      for (int j = 0; j < NH; j++) begin
        if (chan_r[j] < chan_r[i]) begin
          rank[i] = rank[i] + IW'(1);
        end
      end
    end
  end

  always_comb begin
    ord = '0;
    for (int r = 0; r < NH; r++) begin
      for (int i = 0; i < NH; i++) begin
        if (rank[i] == IW'(r)) begin
          ord.stamp[r]  = stamp_r[i];
          ord.energy[r] = energy_r[i];
        end
      end
    end
  end

endmodule

// ===== hw/rtl/fccb_time.sv =====
// Time difference pipeline: coincidence test, offsets, bias and saturation.
`timescale 1ns / 1ps

module fccb_time (
  input  logic                        clk,
  input  logic                        start,
  input  fccb_pkg::stamp_arr_t        stamps,
  input  logic [fccb_pkg::CFG_W-1:0]  coinc_win,
  input  logic signed [fccb_pkg::CFG_W-1:0] pair1_ofs,
  input  logic signed [fccb_pkg::CFG_W-1:0] pair2_ofs,
  output fccb_pkg::time_res_t         res,
  output logic                        coinc_ok
);

  localparam int SW = fccb_pkg::SUM_W;
  localparam int XW = fccb_pkg::SAT_IN_W;

  fccb_pkg::stamp_arr_t t_r;
  fccb_pkg::td_t  d02_r, d13_r, d03_r, d12_r, d10_r, d32_r;
  fccb_pkg::sum_t s_r, d02w_r, d13c_r, d03c_r, d12c_r, d10c_r, d32c_r;
  fccb_pkg::sum_t s2_r;
  logic [SW-1:0]  s_mag;
  logic           ok_r;
  fccb_pkg::time_res_t res_r;

  assign s_mag = s_r[SW-1] ? -s_r : s_r;

  // Stamps are captured at start; the later stages (differences, offset sums,
  // half-sum, saturated results) settle from them while they hold.
  always_ff @(posedge clk) begin
    if (start) begin
      t_r <= stamps;
    end
    d02_r <= fccb_pkg::sdiff(t_r[0], t_r[2]);
    d13_r <= fccb_pkg::sdiff(t_r[1], t_r[3]);
    d03_r <= fccb_pkg::sdiff(t_r[0], t_r[3]);
    d12_r <= fccb_pkg::sdiff(t_r[1], t_r[2]);
    d10_r <= fccb_pkg::sdiff(t_r[1], t_r[0]);
    d32_r <= fccb_pkg::sdiff(t_r[3], t_r[2]);

    s_r    <= SW'(d02_r) + SW'(d13_r);
    d02w_r <= SW'(d02_r);
    d13c_r <= SW'(d13_r) - SW'(pair1_ofs) + SW'(pair2_ofs);
    d03c_r <= SW'(d03_r) + SW'(pair2_ofs);
    d12c_r <= SW'(d12_r) - SW'(pair1_ofs);
    d10c_r <= SW'(d10_r) - SW'(pair1_ofs);
    d32c_r <= SW'(d32_r) - SW'(pair2_ofs);

    ok_r <= s_mag < SW'({coinc_win, 1'b0});
    s2_r <= d02w_r + d13c_r;

    // An arithmetic right shift halves with rounding toward minus infinity.
    res_r.mean_diff   <= fccb_pkg::sat_diff(XW'(s2_r >>> 1) + fccb_pkg::BIAS_S);
    res_r.diff_02     <= fccb_pkg::sat_diff(XW'(d02w_r) + fccb_pkg::BIAS_S);
    res_r.diff_13     <= fccb_pkg::sat_diff(XW'(d13c_r) + fccb_pkg::BIAS_S);
    res_r.diff_03     <= fccb_pkg::sat_diff(XW'(d03c_r) + fccb_pkg::BIAS_S);
    res_r.diff_12     <= fccb_pkg::sat_diff(XW'(d12c_r) + fccb_pkg::BIAS_S);
    res_r.pair1_delta <= fccb_pkg::sat_diff(XW'(d10c_r));
    res_r.pair2_delta <= fccb_pkg::sat_diff(XW'(d32c_r));
  end

  assign res      = res_r;
  assign coinc_ok = ok_r;

endmodule

// ===== hw/rtl/fccb_serial_mul.sv =====
// Bit-serial multiplier of an integral by a Q4.12 gain, one gain bit per cycle.
`timescale 1ns / 1ps

module fccb_serial_mul (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  fccb_pkg::energy_t          energy,
  input  logic [fccb_pkg::CFG_W-1:0] gain,
  output fccb_pkg::prod_t            prod,
  output logic                       done
);

  localparam int PW = fccb_pkg::PROD_W;
  localparam int GW = fccb_pkg::CFG_W;
  localparam int NW = fccb_pkg::MUL_STEP_W;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [NW-1:0]     cnt_r;
  fccb_pkg::energy_t mcand_r;
  logic [GW-1:0]     mplier_r;
  fccb_pkg::prod_t   acc_r, acc_nxt;
  logic              last;

  assign last    = (cnt_r == NW'(GW - 1));
  assign acc_nxt = {acc_r[PW-2:0], 1'b0} + (mplier_r[GW-1] ? PW'(mcand_r) : '0);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
    end else if (busy_r && last) begin
      busy_nxt = 1'b0;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      if (start) begin
        cnt_r <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + NW'(1);
      end
    end
  end

  // Gain bits are taken most significant first from a left-shifting register.
  always_ff @(posedge clk) begin
    if (start) begin
      mcand_r  <= energy;
      mplier_r <= gain;
      acc_r    <= '0;
    end else if (busy_r) begin
      mplier_r <= {mplier_r[GW-2:0], 1'b0};
      acc_r    <= acc_nxt;
    end
  end

  assign prod = acc_r;
  assign done = done_r;

endmodule

// ===== hw/rtl/fccb_asym_div.sv =====
// Restoring divider for one asymmetry (b-a)/(a+b) in Q1.15, one quotient bit per cycle.
`timescale 1ns / 1ps

module fccb_asym_div (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  fccb_pkg::prod_t   a,
  input  fccb_pkg::prod_t   b,
  output fccb_pkg::asym_t   asym,
  output logic              done
);

  localparam int DW = fccb_pkg::DEN_W;
  localparam int RW = fccb_pkg::REM_W;
  localparam int QW = fccb_pkg::QUOT_W;
  localparam int NW = fccb_pkg::DIV_STEP_W;

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [NW-1:0]   cnt_r;
  logic [DW-1:0]   den_r;
  logic [RW-1:0]   rem_r;
  logic [QW-1:0]   q_r;
  logic            neg_r;
  logic            zero_r;
  logic [DW-1:0]   den_in;
  fccb_pkg::prod_t mag_in;
  logic            qbit;
  logic [RW-1:0]   rem_sel;
  logic            last;

  assign den_in = DW'(a) + DW'(b);
  assign mag_in = (b >= a) ? b - a : a - b;
  assign last   = (cnt_r == NW'(QW - 1));

  // The magnitude never exceeds the denominator, so the first step yields the
  // integer bit and the remaining ones the fraction.
  assign qbit    = (rem_r >= RW'(den_r));
  assign rem_sel = qbit ? rem_r - RW'(den_r) : rem_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
    end else if (busy_r && last) begin
      busy_nxt = 1'b0;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      if (start) begin
        cnt_r <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + NW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r  <= den_in;
      rem_r  <= RW'(mag_in);
      q_r    <= '0;
      neg_r  <= (b < a);
      zero_r <= (den_in == '0);
    end else if (busy_r) begin
      rem_r <= {rem_sel[RW-2:0], 1'b0};
      q_r   <= {q_r[QW-2:0], qbit};
    end
  end

  always_comb begin
    if (zero_r) begin
      asym = '0;
    end else if (neg_r) begin
      asym = -q_r;
    end else if (q_r[QW-1]) begin
      asym = fccb_pkg::ASYM_MAX;
    end else begin
      asym = q_r;
    end
  end

  assign done = done_r;

endmodule

// ===== hw/rtl/four_channel_coincidence_builder.sv =====
// Top level of the four-channel coincidence event builder.
`timescale 1ns / 1ps

// Hits arrive on in_ch (valid/ready); each hit is stored in a rolling window
// of the last four hits. When a hit arrives while the window is full, the
// four stored hits are checked first: channels below the limit and distinct,
// time flags set, integrals nonzero. If they pass, one event is computed and
// possibly delivered on out_ch, and the new hit then replaces the oldest.
// A hit that starts no event is taken and ready stays high. A hit that
// starts an event makes the block busy, with ready low, through the
// bit-serial gain multipliers (raw asymmetry dividers run alongside), then
// the gain asymmetry dividers, then the handover. The time path finishes
// inside that span. A result is offered on out_ch once the handover loads
// it, and is dropped if the half-sum mismatch is outside the coincidence
// window. Results wait in an output register; while out_ch is stalled the
// block still takes hits, and only the handover of a new result waits
// for the register to free up.
// The user must write configuration through cfg_we/cfg_idx/cfg_wdata
// only while idle; the block itself does not enforce this.
// Synchronous reset empties the window, clears the output and restores the
// register defaults.
module four_channel_coincidence_builder (
  input  logic                           clk,
  input  logic                           rst_n,
  fccb_in_if.sink                        in_ch,
  fccb_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [fccb_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [fccb_pkg::CFG_W-1:0]     cfg_wdata
);

  localparam int PW = fccb_pkg::PROD_W;
  localparam int GW = fccb_pkg::CFG_W;
  localparam int NH = fccb_pkg::WINDOW_HITS;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0] state_r, state_nxt;

  logic [GW-1:0]        coinc_win_r;
  logic signed [GW-1:0] pair1_ofs_r;
  logic signed [GW-1:0] pair2_ofs_r;
  logic [GW-1:0]        gain_r [NH];

  fccb_pkg::win_hit_t  hit;
  fccb_pkg::win_stat_t wstat;
  fccb_pkg::ord_hits_t ord;
  logic                in_xfer;
  logic                eval_start;

  fccb_pkg::time_res_t tres;
  logic                tm_ok;

  fccb_pkg::prod_t prod_w [NH];
  logic [NH-1:0]   mul_done_w;
  fccb_pkg::asym_t rdiv_asym_w [2];
  logic [1:0]      rdiv_done_w;
  fccb_pkg::asym_t gdiv_asym_w [2];
  logic [1:0]      gdiv_done_w;
  logic            gdiv_start;
  logic            load;

  logic                out_valid_r, out_valid_nxt;
  fccb_pkg::time_res_t out_tres_r;
  fccb_pkg::asym_t     out_asym1_raw_r, out_asym2_raw_r;
  fccb_pkg::asym_t     out_asym1_gain_r, out_asym2_gain_r;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign eval_start  = in_xfer && wstat.full && wstat.qual;
  assign gdiv_start  = (state_r == ST_MUL) && (&{mul_done_w, rdiv_done_w});
  assign load        = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coinc_win_r <= fccb_pkg::RST_COINC_WIN;
      pair1_ofs_r <= '0;
      pair2_ofs_r <= '0;
      for (int k = 0; k < NH; k++) begin
        gain_r[k] <= fccb_pkg::RST_GAIN;
      end
    end else if (cfg_we) begin
      unique case (cfg_idx)
        fccb_pkg::REG_COINC_WIN: coinc_win_r <= cfg_wdata;
        fccb_pkg::REG_PAIR1_OFS: pair1_ofs_r <= cfg_wdata;
        fccb_pkg::REG_PAIR2_OFS: pair2_ofs_r <= cfg_wdata;
        fccb_pkg::REG_GAIN_CH0:  gain_r[0]   <= cfg_wdata;
        fccb_pkg::REG_GAIN_CH1:  gain_r[1]   <= cfg_wdata;
        fccb_pkg::REG_GAIN_CH2:  gain_r[2]   <= cfg_wdata;
        fccb_pkg::REG_GAIN_CH3:  gain_r[3]   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    hit.chan     = in_ch.hit_chan;
    hit.stamp    = in_ch.hit_stamp;
    hit.stamp_ok = in_ch.stamp_ok;
    hit.energy   = in_ch.hit_energy;
  end

  // The arithmetic units capture the sorted window at the same edge at which
  // the new hit enters it.
  fccb_window u_window (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_xfer),
    .hit   (hit),
    .stat  (wstat),
    .ord   (ord)
  );

  fccb_time u_time (
    .clk       (clk),
    .start     (eval_start),
    .stamps    (ord.stamp),
    .coinc_win (coinc_win_r),
    .pair1_ofs (pair1_ofs_r),
    .pair2_ofs (pair2_ofs_r),
    .res       (tres),
    .coinc_ok  (tm_ok)
  );

  for (genvar k = 0; k < NH; k++) begin : g_mul
    fccb_serial_mul u_mul (
      .clk    (clk),
      .rst_n  (rst_n),
      .start  (eval_start),
      .energy (ord.energy[k]),
      .gain   (gain_r[k]),
      .prod   (prod_w[k]),
      .done   (mul_done_w[k])
    );
  end

  for (genvar p = 0; p < 2; p++) begin : g_div
    fccb_asym_div u_rdiv (
      .clk   (clk),
      .rst_n (rst_n),
      .start (eval_start),
      .a     (PW'(ord.energy[2*p])),
      .b     (PW'(ord.energy[2*p+1])),
      .asym  (rdiv_asym_w[p]),
      .done  (rdiv_done_w[p])
    );

    fccb_asym_div u_gdiv (
      .clk   (clk),
      .rst_n (rst_n),
      .start (gdiv_start),
      .a     (prod_w[2*p]),
      .b     (prod_w[2*p+1]),
      .asym  (gdiv_asym_w[p]),
      .done  (gdiv_done_w[p])
    );
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (eval_start) state_nxt = ST_MUL;
      ST_MUL:  if (gdiv_start) state_nxt = ST_DIV;
      ST_DIV:  if (&gdiv_done_w) state_nxt = ST_DONE;
      ST_DONE: if (load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load && tm_ok) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && tm_ok) begin
      out_tres_r       <= tres;
      out_asym1_raw_r  <= rdiv_asym_w[0];
      out_asym2_raw_r  <= rdiv_asym_w[1];
      out_asym1_gain_r <= gdiv_asym_w[0];
      out_asym2_gain_r <= gdiv_asym_w[1];
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.mean_diff   = out_tres_r.mean_diff;
  assign out_ch.diff_02     = out_tres_r.diff_02;
  assign out_ch.diff_13     = out_tres_r.diff_13;
  assign out_ch.diff_03     = out_tres_r.diff_03;
  assign out_ch.diff_12     = out_tres_r.diff_12;
  assign out_ch.pair1_delta = out_tres_r.pair1_delta;
  assign out_ch.pair2_delta = out_tres_r.pair2_delta;
  assign out_ch.asym1_raw   = out_asym1_raw_r;
  assign out_ch.asym2_raw   = out_asym2_raw_r;
  assign out_ch.asym1_gain  = out_asym1_gain_r;
  assign out_ch.asym2_gain  = out_asym2_gain_r;

endmodule

// ===== hw/rtl/fccb_checker.sv =====
// Port-level checker for the coincidence builder and its bind statement.
`timescale 1ns / 1ps
`include "four_channel_coincidence_builder_assert.svh"

module fccb_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input fccb_pkg::diff_t out_mean_diff,
  input fccb_pkg::asym_t out_asym1_raw
);

  // No result may be pending right after reset.
  `FCCB_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "result valid after reset")

  // A stalled result keeps its valid and payload.
  `FCCB_ASSERT(a_stall_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_mean_diff) && $stable(out_asym1_raw), "stalled result changed")

  // A new result is only handed over at the end of a busy event.
  `FCCB_ASSERT(a_result_after_busy, clk, rst_n, $rose(out_valid) |-> !$past(in_ready) && !$past(in_ready, 2), "result without event processing")

  // The block only frees up once the previous result has been taken or was absent.
  `FCCB_ASSERT(a_free_after_handover, clk, rst_n, $rose(in_ready) && $past(rst_n) |-> !$past(out_valid) || $past(out_ready), "result overwritten")

endmodule

bind four_channel_coincidence_builder fccb_checker u_fccb_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_mean_diff (out_ch.mean_diff),
  .out_asym1_raw (out_ch.asym1_raw)
);
